[rtl/mptw_pkg.sv]
package mptw_pkg;

  localparam int PAGE_OFFSET_BITS = 12;
  localparam int LEVEL_COUNT      = 4;
  localparam int POOL_FRAMES      = 256;

  localparam int VA_W        = 48;
  localparam int PHYS_W      = 21;
  localparam int VPN_BITS    = PAGE_OFFSET_BITS - 3;
  localparam int FRAME_W     = $clog2(POOL_FRAMES + 1);
  localparam int FIDX_W      = $clog2(POOL_FRAMES);
  localparam int ADDR_W      = FIDX_W + VPN_BITS;
  localparam int ENT_W       = FRAME_W + 1;
  localparam int STORE_DEPTH = POOL_FRAMES * (1 << VPN_BITS);
  localparam int LVL_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [VPN_BITS-1:0] grp_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [ENT_W-1:0]    entry_t;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_START,
    WS_READ,
    WS_ENTRY,
    WS_RESP
  } mptw_state_t;

  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    addr_t  addr;
    entry_t wr_data;
  } mptw_mem_req_t;

  function automatic logic frame_ok(frame_t f);
    return (f != '0) && (f <= FRAME_W'(POOL_FRAMES));
  endfunction

  function automatic addr_t slot_of(frame_t f, grp_t g);
    logic [FRAME_W-1:0] fm1;
    fm1 = f - FRAME_W'(1);
    return {fm1[FIDX_W-1:0], g};
  endfunction

endpackage

[rtl/mptw_if.sv]
interface mptw_req_if;
  import mptw_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [VA_W-1:0] virt_addr;

  modport source (output valid, output req_type, output virt_addr, input ready);
  modport sink (input valid, input req_type, input virt_addr, output ready);
endinterface

interface mptw_rsp_if;
  import mptw_pkg::*;
  logic              valid;
  logic              ready;
  logic [PHYS_W-1:0] phys_addr;
  logic              fault;
  logic              out_of_frames;

  modport source (output valid, output phys_addr, output fault, output out_of_frames,
                  input ready);
  modport sink (input valid, input phys_addr, input fault, input out_of_frames,
                output ready);
endinterface

[rtl/multilevel_page_table_walker_core.sv]
// multi-level page table walker
// in_ch carries one word per request: req_type (0 translate, 1 allocate) and
// virt_addr; out_ch returns one word per request: phys_addr, fault and
// out_of_frames. both channels move a word when valid and ready are high.
// after reset the table store is swept to zero one entry per cycle, over all
// POOL_FRAMES * 2^(PAGE_OFFSET_BITS-3) entries (131072 by default);
// in_ch.ready stays low until the sweep is done. reset also clears the root
// frame and the frame count.
// a full walk reads the store once per level, then checks the entry and, for
// allocate, writes back a new entry, with a setup step before the levels and
// a response step after them; walks that fault early are shorter.
// the table store has one address for reads and writes, and the walker takes
// a new word only once it is back in idle and the current walk is done.
// the result sits in an output register, so the next word is taken while
// a result waits; if out_ch stalls, the following result holds in the
// walker until the output register frees up.
module multilevel_page_table_walker_core (
  input  logic       clk,
  input  logic       rst_n,
  mptw_req_if.sink   in_ch,
  mptw_rsp_if.source out_ch
);
  import mptw_pkg::*;

  mptw_mem_req_t mem_req;
  entry_t        rd_data;
  logic          store_busy;

  mptw_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  mptw_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .store_busy (store_busy)
  );

endmodule

[rtl/mptw_store.sv]
module mptw_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mptw_pkg::mptw_mem_req_t mem_req,
  output mptw_pkg::entry_t       rd_data,
  output logic                   busy
);
  import mptw_pkg::*;

  entry_t mem [STORE_DEPTH];
  entry_t rd_data_r;
  addr_t  clr_addr_r;
  addr_t  clr_addr_nxt;
  logic   busy_r;
  logic   busy_nxt;
  logic   we;
  addr_t  wa;
  entry_t wd;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign we = busy_r || mem_req.wr_en;
  assign wa = busy_r ? clr_addr_r : mem_req.addr;
  assign wd = busy_r ? '0 : mem_req.wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

[rtl/mptw_walk.sv]
module mptw_walk (
  input  logic                    clk,
  input  logic                    rst_n,
  mptw_req_if.sink                in_ch,
  mptw_rsp_if.source              out_ch,
  output mptw_pkg::mptw_mem_req_t mem_req,
  input  mptw_pkg::entry_t        rd_data,
  input  logic                    store_busy
);
  import mptw_pkg::*;

  mptw_state_t state_r, state_nxt;
  logic                        type_r, type_nxt;
  logic [PAGE_OFFSET_BITS-1:0] off_r, off_nxt;
  grp_t                        grp_r [LEVEL_COUNT];
  grp_t                        grp_nxt [LEVEL_COUNT];
  logic [LVL_W-1:0]            lvl_r, lvl_nxt;
  frame_t                      frame_r, frame_nxt;
  frame_t                      root_r, root_nxt;
  frame_t                      used_r, used_nxt;
  logic [PHYS_W-1:0]           res_phys_r, res_phys_nxt;
  logic                        res_fault_r, res_fault_nxt;
  logic                        res_oof_r, res_oof_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [PHYS_W-1:0]           out_phys_r, out_phys_nxt;
  logic                        out_fault_r, out_fault_nxt;
  logic                        out_oof_r, out_oof_nxt;

  logic        accept;
  logic [63:0] vpn64;
  frame_t      nf;
  logic        hit;
  logic        pool_full;
  frame_t      used_inc;
  logic        lvl_done;

  assign in_ch.ready = (state_r == WS_IDLE) && !store_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign vpn64       = 64'(in_ch.virt_addr >> PAGE_OFFSET_BITS);
  assign nf          = rd_data[ENT_W-1:1];
  assign hit         = rd_data[0] && frame_ok(nf);
  assign pool_full   = used_r >= FRAME_W'(POOL_FRAMES);
  assign used_inc    = used_r + FRAME_W'(1);

  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    off_nxt       = off_r;
    grp_nxt       = grp_r;
    lvl_nxt       = lvl_r;
    frame_nxt     = frame_r;
    root_nxt      = root_r;
    used_nxt      = used_r;
    res_phys_nxt  = res_phys_r;
    res_fault_nxt = res_fault_r;
    res_oof_nxt   = res_oof_r;
    out_valid_nxt = out_valid_r;
    out_phys_nxt  = out_phys_r;
    out_fault_nxt = out_fault_r;
    out_oof_nxt   = out_oof_r;
    lvl_done      = 1'b0;

    mem_req.rd_en   = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.addr    = slot_of(frame_r, grp_r[lvl_r]);
    mem_req.wr_data = {used_inc, 1'b1};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      WS_IDLE: begin
        if (accept) begin
          type_nxt = in_ch.req_type;
          off_nxt  = in_ch.virt_addr[PAGE_OFFSET_BITS-1:0];
          for (int l = 0; l < LEVEL_COUNT; l++) begin
            grp_nxt[l] = VPN_BITS'(vpn64 >> (l * VPN_BITS));
          end
          state_nxt = WS_START;
        end
      end
      WS_START: begin
        res_phys_nxt  = '0;
        res_fault_nxt = 1'b0;
        res_oof_nxt   = 1'b0;
        lvl_nxt       = LVL_W'(LEVEL_COUNT - 1);
        frame_nxt     = root_r;
        state_nxt     = WS_READ;
        if (!frame_ok(root_r)) begin
          if (!type_r) begin
            res_fault_nxt = 1'b1;
            state_nxt     = WS_RESP;
          end else if (pool_full) begin
            res_oof_nxt = 1'b1;
            state_nxt   = WS_RESP;
          end else begin
            used_nxt  = used_inc;
            root_nxt  = used_inc;
            frame_nxt = used_inc;
          end
        end
      end
      WS_READ: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = WS_ENTRY;
      end
      WS_ENTRY: begin
        if (hit) begin
          frame_nxt = nf;
          lvl_done  = 1'b1;
        end else if (!type_r) begin
          res_fault_nxt = 1'b1;
          state_nxt     = WS_RESP;
        end else if (pool_full) begin
          res_oof_nxt = 1'b1;
          state_nxt   = WS_RESP;
        end else begin
          mem_req.wr_en = 1'b1;
          used_nxt      = used_inc;
          frame_nxt     = used_inc;
          lvl_done      = 1'b1;
        end
        if (lvl_done) begin
          if (lvl_r == '0) begin
            if (!type_r) begin
              res_phys_nxt = PHYS_W'({frame_nxt, off_r});
            end
            state_nxt = WS_RESP;
          end else begin
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = WS_READ;
          end
        end
      end
      WS_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_phys_nxt  = res_phys_r;
          out_fault_nxt = res_fault_r;
          out_oof_nxt   = res_oof_r;
          state_nxt     = WS_IDLE;
        end
      end
      default: begin
        state_nxt = WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WS_IDLE;
      root_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r      <= type_nxt;
    off_r       <= off_nxt;
    grp_r       <= grp_nxt;
    lvl_r       <= lvl_nxt;
    frame_r     <= frame_nxt;
    res_phys_r  <= res_phys_nxt;
    res_fault_r <= res_fault_nxt;
    res_oof_r   <= res_oof_nxt;
    out_phys_r  <= out_phys_nxt;
    out_fault_r <= out_fault_nxt;
    out_oof_r   <= out_oof_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.phys_addr     = out_phys_r;
  assign out_ch.fault         = out_fault_r;
  assign out_ch.out_of_frames = out_oof_r;

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> used_r <= FRAME_W'(POOL_FRAMES))
    else $error("frame count beyond pool");

  a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> used_r >= $past(used_r))
    else $error("frame count went backward");

  a_write_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == WS_ENTRY) && type_r && !store_busy)
    else $error("table write outside an allocate walk");

  a_root_stable: assert property (@(posedge clk) disable iff (!rst_n)
    frame_ok($past(root_r)) |-> $stable(root_r))
    else $error("root table changed once set");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !store_busy && (state_r == WS_IDLE))
    else $error("word taken while walker busy");

endmodule
